FILE: rtl/core/olst_pkg.sv
// Shared types and constants for the ordered list store.
package olst_pkg;

    localparam int unsigned CMD_W  = 3;
    localparam int unsigned DATA_W = 32;
    localparam int unsigned ST_W   = 2;

    localparam logic [CMD_W-1:0] CMD_INS_HEAD  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_INS_TAIL  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_INS_AFTER = 3'd2;
    localparam logic [CMD_W-1:0] CMD_DEL_HEAD  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_DEL_TAIL  = 3'd4;
    localparam logic [CMD_W-1:0] CMD_DEL_VALUE = 3'd5;

    localparam logic [ST_W-1:0] ST_OK       = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL     = 2'd1;
    localparam logic [ST_W-1:0] ST_EMPTY    = 2'd2;
    localparam logic [ST_W-1:0] ST_NOTFOUND = 2'd3;

    typedef enum logic [2:0] {
        OP_HOLD       = 3'd0,
        OP_SHIFT_UP   = 3'd1,
        OP_INS_TAIL   = 3'd2,
        OP_INS_AFTER  = 3'd3,
        OP_SHIFT_DOWN = 3'd4,
        OP_DEL_MATCH  = 3'd5
    } t_cell_op;

    typedef struct packed {
        t_cell_op                 op;
        logic                     compare;
        logic signed [DATA_W-1:0] data;
        logic signed [DATA_W-1:0] operand;
    } t_cell_ctl;

endpackage

FILE: rtl/core/ordered_list_store.sv
// Top level of the ordered list store: command control and the row of list cells.
//
// Usage:
//   The slave channel takes one command per transaction: cmd, value and key
//   packed in s_axis_tdata. The master channel returns one transaction per
//   command with the status and the entry count after the command.
//   A command is taken into the command registers on acceptance; in the
//   compare state every cell compares its entry against the key or value,
//   and in the execute state the cells shift in parallel and the result is
//   loaded. The cell row handles one command at a time, so no new command
//   is taken until the last is loaded. A finished result waits in the
//   output register while the next command is taken and compared; if the
//   receiver stalls, the command in the execute state holds until the
//   output register frees. Reset empties the list and drops any pending
//   result; entry contents are not cleared, and positions at or above the
//   count are never read.
module ordered_list_store #(
    parameter int unsigned CAPACITY = 16
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  logic                                       s_axis_tvalid,
    output logic                                       s_axis_tready,
    // cmd [2:0], value [34:3], key [66:35], zero fill to 72 bits
    input  logic [71:0]                                s_axis_tdata,
    output logic                                       m_axis_tvalid,
    input  logic                                       m_axis_tready,
    // status [1:0], count [CW+1:2], zero fill to whole bytes
    output logic [((olst_pkg::ST_W + $clog2(CAPACITY + 1) + 7) / 8) * 8 - 1:0]
                                                       m_axis_tdata
);

    localparam int unsigned CW    = $clog2(CAPACITY + 1);
    localparam int unsigned OUT_W = ((olst_pkg::ST_W + CW + 7) / 8) * 8;
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
    localparam int unsigned DW    = olst_pkg::DATA_W;

    typedef enum logic [2:0] {
        S_IDLE    = 3'b001,
        S_COMPARE = 3'b010,
        S_EXECUTE = 3'b100
    } t_state;

    t_state                      r_state;
    t_state                      n_state;
    logic [olst_pkg::CMD_W-1:0]  r_cmd;
    logic signed [DW-1:0]        r_value;
    logic signed [DW-1:0]        r_key;
    logic [CW-1:0]               r_count;
    logic [CW-1:0]               n_count;
    logic                        r_out_valid;
    logic [olst_pkg::ST_W-1:0]   r_out_status;
    logic [olst_pkg::ST_W-1:0]   n_status;
    logic [CW-1:0]               r_out_count;

    olst_pkg::t_cell_ctl         cell_ctl;
    olst_pkg::t_cell_op          exec_op;
    logic                        commit;
    logic                        accept;
    logic                        empty;
    logic                        full;
    logic                        found;
    logic                        tail_hit;

    logic signed [DW-1:0]        cell_data  [CAPACITY];
    logic [CAPACITY-1:0]         cell_hit;
    logic [CAPACITY-1:0]         cell_before;
    logic [CAPACITY-1:0]         cell_first;
    logic [CAPACITY-1:0]         cell_tail;

    assign accept        = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE);
    assign commit        = (r_state == S_EXECUTE) && (!r_out_valid || m_axis_tready);

    assign empty    = (r_count == '0);
    assign full     = (r_count == CAP_C);
    assign found    = |cell_hit;
    assign tail_hit = |cell_tail;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_COMPARE;
                end
            end
            S_COMPARE: begin
                n_state = S_EXECUTE;
            end
            S_EXECUTE: begin
                if (commit) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        exec_op  = olst_pkg::OP_HOLD;
        n_status = olst_pkg::ST_OK;
        n_count  = r_count;
        unique case (r_cmd)
            olst_pkg::CMD_INS_HEAD, olst_pkg::CMD_INS_TAIL: begin
                if (full) begin
                    n_status = olst_pkg::ST_FULL;
                end else begin
                    exec_op = (r_cmd == olst_pkg::CMD_INS_HEAD) ? olst_pkg::OP_SHIFT_UP
                                                                : olst_pkg::OP_INS_TAIL;
                    n_count = r_count + CW'(1);
                end
            end
            olst_pkg::CMD_INS_AFTER: begin
                if (empty) begin
                    n_status = olst_pkg::ST_EMPTY;
                end else if (full) begin
                    n_status = olst_pkg::ST_FULL;
                end else if (!found) begin
                    n_status = olst_pkg::ST_NOTFOUND;
                end else begin
                    exec_op = olst_pkg::OP_INS_AFTER;
                    n_count = r_count + CW'(1);
                end
            end
            olst_pkg::CMD_DEL_HEAD: begin
                if (empty) begin
                    n_status = olst_pkg::ST_EMPTY;
                end else begin
                    exec_op = olst_pkg::OP_SHIFT_DOWN;
                    n_count = r_count - CW'(1);
                end
            end
            olst_pkg::CMD_DEL_TAIL: begin
                if (empty) begin
                    n_status = olst_pkg::ST_EMPTY;
                end else begin
                    n_count = r_count - CW'(1);
                end
            end
            olst_pkg::CMD_DEL_VALUE: begin
                if (empty) begin
                    n_status = olst_pkg::ST_EMPTY;
                end else if (tail_hit) begin
                    n_count = r_count - CW'(1);
                end else if (!found) begin
                    n_status = olst_pkg::ST_NOTFOUND;
                end else begin
                    exec_op = olst_pkg::OP_DEL_MATCH;
                    n_count = r_count - CW'(1);
                end
            end
            default: begin
                n_status = olst_pkg::ST_OK;
            end
        endcase
    end

    always_comb begin
        cell_ctl.op      = commit ? exec_op : olst_pkg::OP_HOLD;
        cell_ctl.compare = (r_state == S_COMPARE);
        cell_ctl.data    = r_value;
        cell_ctl.operand = (r_cmd == olst_pkg::CMD_INS_AFTER) ? r_key : r_value;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (commit) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd   <= s_axis_tdata[2:0];
            r_value <= s_axis_tdata[34:3];
            r_key   <= s_axis_tdata[66:35];
        end
        if (commit) begin
            r_out_status <= n_status;
            r_out_count  <= n_count;
        end
    end

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic signed [DW-1:0] left_data;
        logic signed [DW-1:0] right_data;
        logic                 hit_before;
        logic                 left_first;

        if (g == 0) begin : g_head
            assign left_data  = r_value;
            assign hit_before = 1'b0;
            assign left_first = 1'b0;
        end else begin : g_body
            assign left_data  = cell_data[g-1];
            assign hit_before = cell_before[g-1];
            assign left_first = cell_first[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign right_data = cell_data[g];
        end else begin : g_inner
            assign right_data = cell_data[g+1];
        end

        olst_cell #(
            .CAPACITY (CAPACITY),
            .INDEX    (g),
            .CW       (CW)
        ) u_cell (
            .i_clk             (i_clk),
            .i_rst_n           (i_rst_n),
            .i_ctl             (cell_ctl),
            .i_count           (r_count),
            .i_left_data       (left_data),
            .i_right_data      (right_data),
            .i_hit_before      (hit_before),
            .i_left_first      (left_first),
            .o_data            (cell_data[g]),
            .o_hit             (cell_hit[g]),
            .o_hit_before_next (cell_before[g]),
            .o_first           (cell_first[g]),
            .o_tail_hit        (cell_tail[g])
        );
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_W'({r_out_count, r_out_status});

endmodule

FILE: rtl/core/olst_cell.sv
// One list position: holds an entry, matches it and shifts it with its neighbors.
module olst_cell #(
    parameter int unsigned CAPACITY = 16,
    parameter int unsigned INDEX    = 0,
    parameter int unsigned CW       = $clog2(CAPACITY + 1)
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  olst_pkg::t_cell_ctl               i_ctl,
    input  logic [CW-1:0]                     i_count,
    input  logic signed [olst_pkg::DATA_W-1:0] i_left_data,
    input  logic signed [olst_pkg::DATA_W-1:0] i_right_data,
    input  logic                              i_hit_before,
    input  logic                              i_left_first,
    output logic signed [olst_pkg::DATA_W-1:0] o_data,
    output logic                              o_hit,
    output logic                              o_hit_before_next,
    output logic                              o_first,
    output logic                              o_tail_hit
);

    localparam logic [CW-1:0] INDEX_C  = CW'(INDEX);
    localparam logic [CW-1:0] INDEX_P1 = CW'(INDEX + 1);

    logic signed [olst_pkg::DATA_W-1:0] r_data;
    logic signed [olst_pkg::DATA_W-1:0] n_data;
    logic                               r_hit;

    always_comb begin
        n_data = r_data;
        case (i_ctl.op)
            olst_pkg::OP_SHIFT_UP: begin
                n_data = i_left_data;
            end
            olst_pkg::OP_INS_TAIL: begin
                if (i_count == INDEX_C) begin
                    n_data = i_ctl.data;
                end
            end
            olst_pkg::OP_INS_AFTER: begin
                if (i_left_first) begin
                    n_data = i_ctl.data;
                end else if (i_hit_before) begin
                    n_data = i_left_data;
                end
            end
            olst_pkg::OP_SHIFT_DOWN: begin
                n_data = i_right_data;
            end
            olst_pkg::OP_DEL_MATCH: begin
                if (r_hit || i_hit_before) begin
                    n_data = i_right_data;
                end
            end
            default: begin
                n_data = r_data;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit <= 1'b0;
        end else if (i_ctl.compare) begin
            r_hit <= (r_data == i_ctl.operand) && (INDEX_C < i_count);
        end
    end

    assign o_data            = r_data;
    assign o_hit             = r_hit;
    assign o_hit_before_next = r_hit || i_hit_before;
    assign o_first           = r_hit && !i_hit_before;
    assign o_tail_hit        = r_hit && (i_count == INDEX_P1);

endmodule

FILE: verif/ordered_list_store_test.sv
// Testbench for ordered_list_store: list commands over the stream ports, checked by a queue.
module ordered_list_store_test;

    localparam int unsigned CAPACITY  = 16;
    localparam int unsigned CNT_W     = $clog2(CAPACITY + 1);
    localparam int unsigned OUT_W     = ((olst_pkg::ST_W + CNT_W + 7) / 8) * 8;
    localparam int unsigned CYCLE_CAP = 200000;

    localparam logic [olst_pkg::CMD_W-1:0] CMD_RSVD_6 = 3'd6;
    localparam logic [olst_pkg::CMD_W-1:0] CMD_RSVD_7 = 3'd7;

    typedef struct packed {
        logic [olst_pkg::ST_W-1:0] status;
        logic [CNT_W-1:0]          count;
    } t_list_reply;

    logic              i_clk         = 1'b0;
    logic              i_rst_n       = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    // cmd [2:0], value [34:3], key [66:35], zero fill to 72 bits
    logic [71:0]       s_axis_tdata  = '0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    // status [1:0], count [CNT_W+1:2], zero fill to whole bytes
    logic [OUT_W-1:0]  m_axis_tdata;

    logic signed [olst_pkg::DATA_W-1:0] list_mem[$];
    t_list_reply              reply_q[$];
    int unsigned              errors     = 0;
    int unsigned              cycle_cnt  = 0;
    int unsigned              sink_hold  = 0;
    bit                       idle_on    = 1'b1;

    ordered_list_store #(
        .CAPACITY(CAPACITY)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        forever begin
            @(posedge i_clk);
            cycle_cnt++;
            if (cycle_cnt > CYCLE_CAP) begin
                $display("ordered_list_store_test: done, errors");
                $finish;
            end
        end
    end

    function automatic int find_first_entry(input logic signed [olst_pkg::DATA_W-1:0] word);
        for (int i = 0; i < list_mem.size(); i++) begin
            if (list_mem[i] == word) return i;
        end
        return -1;
    endfunction

    function automatic t_list_reply apply_list_command(
        input logic [olst_pkg::CMD_W-1:0]          cmd,
        input logic signed [olst_pkg::DATA_W-1:0]  value,
        input logic signed [olst_pkg::DATA_W-1:0]  key);
        t_list_reply r;
        int          pos;
        r.status = olst_pkg::ST_OK;
        case (cmd)
            olst_pkg::CMD_INS_HEAD: begin
                if (list_mem.size() >= CAPACITY) r.status = olst_pkg::ST_FULL;
                else list_mem.push_front(value);
            end
            olst_pkg::CMD_INS_TAIL: begin
                if (list_mem.size() >= CAPACITY) r.status = olst_pkg::ST_FULL;
                else list_mem.push_back(value);
            end
            olst_pkg::CMD_INS_AFTER: begin
                pos = find_first_entry(key);
                if (list_mem.size() == 0) r.status = olst_pkg::ST_EMPTY;
                else if (list_mem.size() >= CAPACITY) r.status = olst_pkg::ST_FULL;
                else if (pos < 0) r.status = olst_pkg::ST_NOTFOUND;
                else list_mem.insert(pos + 1, value);
            end
            olst_pkg::CMD_DEL_HEAD: begin
                if (list_mem.size() == 0) r.status = olst_pkg::ST_EMPTY;
                else void'(list_mem.pop_front());
            end
            olst_pkg::CMD_DEL_TAIL: begin
                if (list_mem.size() == 0) r.status = olst_pkg::ST_EMPTY;
                else void'(list_mem.pop_back());
            end
            olst_pkg::CMD_DEL_VALUE: begin
                if (list_mem.size() == 0) begin
                    r.status = olst_pkg::ST_EMPTY;
                end else if (list_mem[list_mem.size() - 1] == value) begin
                    void'(list_mem.pop_back());
                end else begin
                    pos = find_first_entry(value);
                    if (pos < 0) r.status = olst_pkg::ST_NOTFOUND;
                    else list_mem.delete(pos);
                end
            end
            default: ;
        endcase
        r.count = CNT_W'(list_mem.size());
        return r;
    endfunction

    task automatic send_command(input logic [olst_pkg::CMD_W-1:0]         cmd,
                                input logic signed [olst_pkg::DATA_W-1:0] value,
                                input logic signed [olst_pkg::DATA_W-1:0] key);
        int unsigned gap;
        gap = idle_on ? $urandom_range(0, 3) : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'd0, key, value, cmd};
        do @(posedge i_clk); while (!s_axis_tready);
        reply_q.push_back(apply_list_command(cmd, value, key));
    endtask

    task automatic wait_for_results();
        s_axis_tvalid <= 1'b0;
        while (reply_q.size() != 0) @(posedge i_clk);
    endtask

    initial begin : result_sink
        int unsigned wait_left;
        wait_left = 0;
        forever begin
            @(posedge i_clk);
            if (m_axis_tvalid && m_axis_tready) wait_left = idle_on ? $urandom_range(0, 3) : 0;
            if (sink_hold > 0) begin
                sink_hold--;
                m_axis_tready <= 1'b0;
            end else if (wait_left > 0) begin
                wait_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    initial begin : result_check
        t_list_reply               want;
        logic [olst_pkg::ST_W-1:0] got_status;
        logic [CNT_W-1:0]          got_count;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
                got_status = m_axis_tdata[olst_pkg::ST_W-1:0];
                got_count  = m_axis_tdata[olst_pkg::ST_W +: CNT_W];
                if (reply_q.size() == 0) begin
                    $display("%0t: unexpected result status %0d count %0d",
                             $time, got_status, got_count);
                    errors++;
                end else begin
                    want = reply_q.pop_front();
                    if (got_status !== want.status) begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, got_status);
                        errors++;
                    end
                    if (got_count !== want.count) begin
                        $display("%0t: count expected %0d actual %0d",
                                 $time, want.count, got_count);
                        errors++;
                    end
                end
            end
        end
    end

    function automatic logic signed [olst_pkg::DATA_W-1:0] pick_word(
        input int unsigned present_pct);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (list_mem.size() > 0 && r < present_pct)
            return list_mem[$urandom_range(0, list_mem.size() - 1)];
        if (r < present_pct + 25) begin
            case ($urandom_range(0, 5))
                0: return 32'sh0000_0000;
                1: return 32'sh0000_0001;
                2: return 32'shFFFF_FFFF;
                3: return 32'sh7FFF_FFFF;
                4: return 32'sh8000_0000;
                default: return 32'sh5A5A_5A5A;
            endcase
        end
        return $urandom;
    endfunction

    function automatic logic [olst_pkg::CMD_W-1:0] pick_cmd(input int unsigned fill_pct);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 4) return r[0] ? CMD_RSVD_7 : CMD_RSVD_6;
        if ($urandom_range(0, 99) < fill_pct) begin
            case ($urandom_range(0, 2))
                0: return olst_pkg::CMD_INS_HEAD;
                1: return olst_pkg::CMD_INS_TAIL;
                default: return olst_pkg::CMD_INS_AFTER;
            endcase
        end
        case ($urandom_range(0, 2))
            0: return olst_pkg::CMD_DEL_HEAD;
            1: return olst_pkg::CMD_DEL_TAIL;
            default: return olst_pkg::CMD_DEL_VALUE;
        endcase
    endfunction

    task automatic send_random_command(input int unsigned fill_pct);
        logic [olst_pkg::CMD_W-1:0]         cmd;
        logic signed [olst_pkg::DATA_W-1:0] value;
        logic signed [olst_pkg::DATA_W-1:0] key;
        cmd   = pick_cmd(fill_pct);
        value = pick_word(cmd == olst_pkg::CMD_DEL_VALUE ? 60 : 30);
        key   = pick_word(70);
        send_command(cmd, value, key);
    endtask

    task automatic test_empty_list();
        send_command(olst_pkg::CMD_DEL_HEAD, 32'sh7FFF_FFFF, 32'sh8000_0000);
        send_command(olst_pkg::CMD_DEL_TAIL, 32'sh8000_0000, 32'sh7FFF_FFFF);
        send_command(olst_pkg::CMD_DEL_VALUE, 32'sh0000_0000, 32'shFFFF_FFFF);
        send_command(olst_pkg::CMD_INS_AFTER, 32'shFFFF_FFFF, 32'sh0000_0000);
        send_command(CMD_RSVD_6, 32'shFFFF_FFFF, 32'shFFFF_FFFF);
        send_command(CMD_RSVD_7, 32'sh0000_0000, 32'sh0000_0000);
    endtask

    task automatic test_directed_ops();
        send_command(olst_pkg::CMD_INS_TAIL, 32'sh7FFF_FFFF, 32'sh0000_0000);
        send_command(olst_pkg::CMD_INS_HEAD, 32'sh8000_0000, 32'shFFFF_FFFF);
        send_command(olst_pkg::CMD_INS_AFTER, 32'sh0000_0000, 32'sh7FFF_FFFF);
        send_command(olst_pkg::CMD_INS_AFTER, 32'sh0000_0001, 32'sh8000_0000);
        send_command(olst_pkg::CMD_INS_AFTER, 32'sh0000_0005, 32'sh1234_5678);
        send_command(olst_pkg::CMD_DEL_VALUE, 32'sh1234_5678, 32'sh0000_0000);
        send_command(olst_pkg::CMD_INS_TAIL, 32'sh8000_0000, 32'sh0000_0000);
        send_command(olst_pkg::CMD_DEL_VALUE, 32'sh8000_0000, 32'sh0000_0000);
        send_command(olst_pkg::CMD_INS_TAIL, 32'sh0000_0001, 32'sh0000_0000);
        send_command(olst_pkg::CMD_INS_AFTER, 32'shFFFF_FFFF, 32'sh0000_0001);
        send_command(olst_pkg::CMD_DEL_VALUE, 32'sh0000_0001, 32'sh0000_0000);
        send_command(olst_pkg::CMD_DEL_VALUE, 32'sh7FFF_FFFF, 32'sh0000_0000);
        send_command(olst_pkg::CMD_DEL_VALUE, 32'sh8000_0000, 32'sh0000_0000);
        send_command(olst_pkg::CMD_DEL_HEAD, 32'sh0000_0000, 32'sh0000_0000);
        send_command(olst_pkg::CMD_DEL_TAIL, 32'sh0000_0000, 32'sh0000_0000);
        send_command(olst_pkg::CMD_DEL_TAIL, 32'sh0000_0000, 32'sh0000_0000);
    endtask

    task automatic test_random_traffic(input int unsigned n_items, input bit fill_start);
        int unsigned sent;
        int unsigned epoch_len;
        int unsigned fill_pct;
        sent = 0;
        while (sent < n_items) begin
            if (fill_start && sent == 0) begin
                epoch_len = 40;
                fill_pct  = 100;
            end else begin
                epoch_len = $urandom_range(10, 40);
                case ($urandom_range(0, 2))
                    0: fill_pct = 85;
                    1: fill_pct = 15;
                    default: fill_pct = 50;
                endcase
            end
            idle_on = ($urandom_range(0, 3) != 0);
            for (int unsigned i = 0; i < epoch_len && sent < n_items; i++) begin
                send_random_command(fill_pct);
                sent++;
            end
        end
        idle_on = 1'b1;
    endtask

    task automatic test_output_stall();
        sink_hold = 80;
        for (int i = 0; i < 30; i++) send_random_command(60);
    endtask

    task automatic test_sender_pause();
        for (int burst = 0; burst < 6; burst++) begin
            for (int i = 0; i < 5; i++) send_random_command(50);
            wait_for_results();
        end
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_empty_list();
        test_directed_ops();
        wait_for_results();
        test_random_traffic(850, 1'b1);
        test_output_stall();
        test_sender_pause();
        test_random_traffic(900, 1'b0);
        wait_for_results();
        repeat (8) @(posedge i_clk);
        if (errors == 0) begin
            $display("ordered_list_store_test: done, clean");
        end else begin
            $display("ordered_list_store_test: done, errors");
        end
        $finish;
    end

endmodule
